### rtl/core/sync_length_checksum_deframer_assert.svh
// Assertion macros for the deframer. Each one expands to nothing in synthesis.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define SLD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("deframer assertion failed");
`define SLD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("deframer assertion failed");
`else
`define SLD_ASSERT(lbl, clk, rstn, prop)
`define SLD_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### rtl/core/sld_pkg.sv
package sld_pkg;

  localparam int unsigned SyncLenDefault      = 2;
  localparam int unsigned BufferDepthDefault  = 128;
  localparam int unsigned PayloadLimitDefault = 64;
  localparam int unsigned CfgAddrWidth        = 5;

  localparam logic [1:0] CksNone = 2'd0;
  localparam logic [1:0] CksXor  = 2'd2;

  typedef enum logic [2:0] {
    REG_SYNC_PATTERN   = 3'd0,
    REG_ID_OFFSET      = 3'd1,
    REG_ID_BYTES       = 3'd2,
    REG_LENGTH_OFFSET  = 3'd3,
    REG_LENGTH_BYTES   = 3'd4,
    REG_LENGTH_INCL    = 3'd5,
    REG_MAX_PAYLOAD    = 3'd6,
    REG_CHECKSUM_MODE  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] sync_pattern;
    logic [3:0]  id_start;
    logic [2:0]  id_width;
    logic [3:0]  len_start;
    logic [1:0]  len_width;
    logic        length_incl;
    logic [6:0]  pay_max;
    logic [1:0]  checksum_mode;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_APPEND,
    OP_NEXT_POS,
    OP_K_INC,
    OP_K_CLR,
    OP_HDR_INIT,
    OP_HDR_ACC,
    OP_EVAL,
    OP_REJECT,
    OP_PAY_ACC,
    OP_EMIT_INIT,
    OP_LOAD_OUT,
    OP_LOAD_ZERO,
    OP_ACCEPT_DONE,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic no_room;
    logic sync_match;
    logic k_last_sync;
    logic hdr_short;
    logic hdr_zero;
    logic hdr_last;
    logic reject_len;
    logic frame_short;
    logic cks_on;
    logic pay_done;
    logic cks_ok;
    logic plen_zero;
    logic out_last;
  } dp_status_t;

endpackage

### rtl/core/sld_ifs.sv
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface sld_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_id;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic [6:0]  payload_length;
  logic        last;
  modport source (output valid, output frame_id, output payload_byte, output byte_valid,
                  output payload_length, output last, input ready);
  modport sink (input valid, input frame_id, input payload_byte, input byte_valid,
                input payload_length, input last, output ready);
endinterface

### rtl/core/sld_ram.sv
module sld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sld_cfg.sv
module sld_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sld_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output sld_pkg::cfg_t                   cfg_o
);

  sld_pkg::cfg_t    cfg_q;
  sld_pkg::reg_idx_e idx;
  logic             wr;

  assign idx    = sld_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_pattern  <= 32'h0000_AA55;
      cfg_q.id_start      <= 4'd2;
      cfg_q.id_width      <= 3'd1;
      cfg_q.len_start     <= 4'd3;
      cfg_q.len_width     <= 2'd1;
      cfg_q.length_incl   <= 1'b0;
      cfg_q.pay_max       <= 7'd64;
      cfg_q.checksum_mode <= 2'd1;
    end else if (wr) begin
      unique case (idx)
        sld_pkg::REG_SYNC_PATTERN:  cfg_q.sync_pattern  <= pwdata;
        sld_pkg::REG_ID_OFFSET:     cfg_q.id_start      <= pwdata[3:0];
        sld_pkg::REG_ID_BYTES:      cfg_q.id_width      <= pwdata[2:0];
        sld_pkg::REG_LENGTH_OFFSET: cfg_q.len_start     <= pwdata[3:0];
        sld_pkg::REG_LENGTH_BYTES:  cfg_q.len_width     <= pwdata[1:0];
        sld_pkg::REG_LENGTH_INCL:   cfg_q.length_incl   <= pwdata[0];
        sld_pkg::REG_MAX_PAYLOAD:   cfg_q.pay_max       <= pwdata[6:0];
        sld_pkg::REG_CHECKSUM_MODE: cfg_q.checksum_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sld_pkg::REG_SYNC_PATTERN:  prdata = cfg_q.sync_pattern;
      sld_pkg::REG_ID_OFFSET:     prdata = {28'd0, cfg_q.id_start};
      sld_pkg::REG_ID_BYTES:      prdata = {29'd0, cfg_q.id_width};
      sld_pkg::REG_LENGTH_OFFSET: prdata = {28'd0, cfg_q.len_start};
      sld_pkg::REG_LENGTH_BYTES:  prdata = {30'd0, cfg_q.len_width};
      sld_pkg::REG_LENGTH_INCL:   prdata = {31'd0, cfg_q.length_incl};
      sld_pkg::REG_MAX_PAYLOAD:   prdata = {25'd0, cfg_q.pay_max};
      sld_pkg::REG_CHECKSUM_MODE: prdata = {30'd0, cfg_q.checksum_mode};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/sld_dp.sv
`include "sync_length_checksum_deframer_assert.svh"

module sld_dp #(
  parameter int unsigned SyncLen      = sld_pkg::SyncLenDefault,
  parameter int unsigned BufferDepth  = sld_pkg::BufferDepthDefault,
  parameter int unsigned PayloadLimit = sld_pkg::PayloadLimitDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sld_pkg::cfg_t       cfg_i,
  input  sld_pkg::dp_cmd_t    cmd_i,
  input  logic [7:0]          in_byte_i,
  output sld_pkg::dp_status_t status_o,
  output logic [31:0]         frame_id_o,
  output logic [7:0]          payload_byte_o,
  output logic                byte_valid_o,
  output logic [6:0]          payload_length_o,
  output logic                last_o
);

  localparam int unsigned AW  = $clog2(BufferDepth);
  localparam int unsigned CW  = $clog2(BufferDepth + 1);
  localparam int unsigned OW  = (CW > 7) ? CW : 7;
  localparam int unsigned KSW = (SyncLen > 1) ? $clog2(SyncLen) : 1;
  localparam logic [AW:0] DepthW = (AW + 1)'(BufferDepth);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [OW-1:0] pos_q, pos_d, k_q, k_d;
  logic [7:0]    byte_q, byte_d, acc_q, acc_d, out_byte_q, out_byte_d;
  logic [31:0]   fid_q, fid_d;
  logic [15:0]   len_q, len_d;
  logic [6:0]    plen_q, plen_d, total_q, total_d;
  logic          out_bv_q, out_bv_d, last_q, last_d;

  logic [7:0]    rdata;
  logic [OW:0]   rel;
  logic [AW:0]   raddr_raw, waddr_raw, head_inc_raw, fin_raw;
  logic [AW-1:0] raddr, waddr, head_app;
  logic [CW-1:0] count_app, fin_step;
  logic          full, we;

  logic [2:0]    nid;
  logic [1:0]    nlen;
  logic [4:0]    id_end, len_end, hdr;
  logic [6:0]    limit;
  logic          cks_on, is_xor;
  logic [OW-1:0] cnt_ext, avail;
  logic [KSW-1:0] ks;
  logic [4:0]    sb_shift;
  logic [7:0]    sync_b;
  logic [16:0]   diff;
  logic          in_id, in_len;
  logic [7:0]    acc_next;

  // Storage addresses wrap once, since both operands stay below the depth.
  assign rel       = {1'b0, pos_q} + {1'b0, k_q};
  assign raddr_raw = {1'b0, head_q} + rel[AW:0];
  assign raddr     = (raddr_raw >= DepthW) ? AW'(raddr_raw - DepthW) : raddr_raw[AW-1:0];

  assign full         = (count_q == CW'(BufferDepth));
  assign head_inc_raw = {1'b0, head_q} + (AW + 1)'(1);
  assign head_app     = full ? ((head_inc_raw >= DepthW) ? AW'(head_inc_raw - DepthW)
                                                         : head_inc_raw[AW-1:0])
                             : head_q;
  assign count_app    = full ? CW'(BufferDepth - 1) : count_q;
  assign waddr_raw    = {1'b0, head_app} + (AW + 1)'(count_app);
  assign waddr        = (waddr_raw >= DepthW) ? AW'(waddr_raw - DepthW) : waddr_raw[AW-1:0];
  assign we           = (cmd_i.op == sld_pkg::OP_APPEND);

  assign fin_step = (OW'(pos_q) > cnt_ext) ? count_q : CW'(pos_q);
  assign fin_raw  = {1'b0, head_q} + (AW + 1)'(fin_step);

  sld_ram #(.Width(8), .Depth(BufferDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (byte_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Effective frame layout from configuration.
  assign nid     = (cfg_i.id_width > 3'd4) ? 3'd4 : cfg_i.id_width;
  assign nlen    = (cfg_i.len_width > 2'd2) ? 2'd2 : cfg_i.len_width;
  assign id_end  = {1'b0, cfg_i.id_start} + {2'b0, nid};
  assign len_end = {1'b0, cfg_i.len_start} + {3'b0, nlen};
  assign hdr     = (id_end > len_end) ? id_end : len_end;
  assign limit   = (cfg_i.pay_max < 7'(PayloadLimit)) ? cfg_i.pay_max
                                                      : 7'(PayloadLimit);
  assign cks_on  = (cfg_i.checksum_mode != sld_pkg::CksNone);
  assign is_xor  = (cfg_i.checksum_mode == sld_pkg::CksXor);

  assign cnt_ext  = OW'(count_q);
  assign avail    = cnt_ext - pos_q;
  assign ks       = k_q[KSW-1:0];
  assign sb_shift = 5'(8 * (SyncLen - 1 - int'(ks)));
  assign sync_b   = 8'(cfg_i.sync_pattern >> sb_shift);

  assign in_id  = (k_q >= OW'(cfg_i.id_start)) &&
                  ((k_q - OW'(cfg_i.id_start)) < OW'(nid));
  assign in_len = (k_q >= OW'(cfg_i.len_start)) &&
                  ((k_q - OW'(cfg_i.len_start)) < OW'(nlen));
  assign acc_next = is_xor ? (acc_q ^ rdata) : (acc_q + rdata);

  assign diff = cfg_i.length_incl ? ({1'b0, len_q} - 17'(hdr)) : {1'b0, len_q};

  always_comb begin
    status_o.no_room     = (({1'b0, pos_q} + (OW + 1)'(SyncLen)) > {1'b0, cnt_ext});
    status_o.sync_match  = (rdata == sync_b);
    status_o.k_last_sync = (k_q == OW'(SyncLen - 1));
    status_o.hdr_short   = (avail < OW'(hdr));
    status_o.hdr_zero    = (hdr == 5'd0);
    status_o.hdr_last    = ((k_q + OW'(1)) == OW'(hdr));
    status_o.reject_len  = diff[16] || (diff > 17'(limit));
    status_o.frame_short = (avail < OW'(total_q));
    status_o.cks_on      = cks_on;
    status_o.pay_done    = ((k_q + OW'(1)) == OW'(total_q));
    status_o.cks_ok      = (acc_q == rdata);
    status_o.plen_zero   = (plen_q == 7'd0);
    status_o.out_last    = last_q;
  end

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    pos_d      = pos_q;
    k_d        = k_q;
    byte_d     = byte_q;
    acc_d      = acc_q;
    fid_d      = fid_q;
    len_d      = len_q;
    plen_d     = plen_q;
    total_d    = total_q;
    out_byte_d = out_byte_q;
    out_bv_d   = out_bv_q;
    last_d     = last_q;
    unique case (cmd_i.op)
      sld_pkg::OP_LATCH: byte_d = in_byte_i;
      sld_pkg::OP_APPEND: begin
        head_d  = head_app;
        count_d = count_app + CW'(1);
        pos_d   = '0;
        k_d     = '0;
      end
      sld_pkg::OP_NEXT_POS: begin
        pos_d = pos_q + OW'(1);
        k_d   = '0;
      end
      sld_pkg::OP_K_INC: k_d = k_q + OW'(1);
      sld_pkg::OP_K_CLR: k_d = '0;
      sld_pkg::OP_HDR_INIT: begin
        k_d   = '0;
        acc_d = '0;
        fid_d = '0;
        len_d = '0;
      end
      sld_pkg::OP_HDR_ACC: begin
        acc_d = acc_next;
        if (in_id) begin
          fid_d = {fid_q[23:0], rdata};
        end
        if (in_len) begin
          len_d = {len_q[7:0], rdata};
        end
        k_d = k_q + OW'(1);
      end
      sld_pkg::OP_EVAL: begin
        plen_d  = diff[6:0];
        total_d = 7'(hdr) + diff[6:0] + 7'(cks_on);
      end
      sld_pkg::OP_REJECT: begin
        pos_d = pos_q + OW'(SyncLen);
        k_d   = '0;
      end
      sld_pkg::OP_PAY_ACC: begin
        acc_d = acc_next;
        k_d   = k_q + OW'(1);
      end
      sld_pkg::OP_EMIT_INIT: k_d = OW'(hdr);
      sld_pkg::OP_LOAD_OUT: begin
        out_byte_d = rdata;
        out_bv_d   = 1'b1;
        last_d     = (k_q == (OW'(hdr) + OW'(plen_q) - OW'(1)));
        k_d        = k_q + OW'(1);
      end
      sld_pkg::OP_LOAD_ZERO: begin
        out_byte_d = '0;
        out_bv_d   = 1'b0;
        last_d     = 1'b1;
      end
      sld_pkg::OP_ACCEPT_DONE: begin
        pos_d = pos_q + ((total_q == 7'd0) ? OW'(1) : OW'(total_q));
      end
      sld_pkg::OP_FINISH: begin
        head_d  = (fin_raw >= DepthW) ? AW'(fin_raw - DepthW) : fin_raw[AW-1:0];
        count_d = count_q - fin_step;
        pos_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      k_q     <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    acc_q      <= acc_d;
    fid_q      <= fid_d;
    len_q      <= len_d;
    plen_q     <= plen_d;
    total_q    <= total_d;
    out_byte_q <= out_byte_d;
    out_bv_q   <= out_bv_d;
    last_q     <= last_d;
  end

  assign frame_id_o       = fid_q;
  assign payload_byte_o   = out_byte_q;
  assign byte_valid_o     = out_bv_q;
  assign payload_length_o = plen_q;
  assign last_o           = last_q;

  `SLD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(BufferDepth))
  `SLD_ASSERT(a_head_bound, clk_i, rst_ni, head_q <= AW'(BufferDepth - 1))
  `SLD_ASSERT(a_fin_pos, clk_i, rst_ni, (cmd_i.op == sld_pkg::OP_FINISH) |-> (pos_q <= cnt_ext))

endmodule

### rtl/core/sld_ctrl.sv
`include "sync_length_checksum_deframer_assert.svh"

module sld_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sld_pkg::dp_status_t status_i,
  output sld_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_SRCH, S_SCMP, S_HCHK, S_HRD, S_HACC, S_HEVAL,
    S_TCHK, S_PRD, S_PACC, S_EMIT, S_ELOAD, S_EOUT, S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = sld_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = sld_pkg::OP_LATCH;
          state_d  = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.op = sld_pkg::OP_APPEND;
        state_d  = S_SRCH;
      end
      S_SRCH: state_d = status_i.no_room ? S_FIN : S_SCMP;
      S_SCMP: begin
        if (!status_i.sync_match) begin
          cmd_o.op = sld_pkg::OP_NEXT_POS;
          state_d  = S_SRCH;
        end else if (status_i.k_last_sync) begin
          cmd_o.op = sld_pkg::OP_K_CLR;
          state_d  = S_HCHK;
        end else begin
          cmd_o.op = sld_pkg::OP_K_INC;
          state_d  = S_SRCH;
        end
      end
      S_HCHK: begin
        if (status_i.hdr_short) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = sld_pkg::OP_HDR_INIT;
          state_d  = status_i.hdr_zero ? S_HEVAL : S_HRD;
        end
      end
      S_HRD: state_d = S_HACC;
      S_HACC: begin
        cmd_o.op = sld_pkg::OP_HDR_ACC;
        state_d  = status_i.hdr_last ? S_HEVAL : S_HRD;
      end
      S_HEVAL: begin
        if (status_i.reject_len) begin
          cmd_o.op = sld_pkg::OP_REJECT;
          state_d  = S_SRCH;
        end else begin
          cmd_o.op = sld_pkg::OP_EVAL;
          state_d  = S_TCHK;
        end
      end
      S_TCHK: begin
        if (status_i.frame_short) begin
          state_d = S_FIN;
        end else if (status_i.cks_on) begin
          state_d = S_PRD;
        end else begin
          cmd_o.op = sld_pkg::OP_EMIT_INIT;
          state_d  = S_EMIT;
        end
      end
      S_PRD: state_d = S_PACC;
      S_PACC: begin
        if (!status_i.pay_done) begin
          cmd_o.op = sld_pkg::OP_PAY_ACC;
          state_d  = S_PRD;
        end else if (status_i.cks_ok) begin
          cmd_o.op = sld_pkg::OP_EMIT_INIT;
          state_d  = S_EMIT;
        end else begin
          cmd_o.op = sld_pkg::OP_REJECT;
          state_d  = S_SRCH;
        end
      end
      S_EMIT: begin
        if (status_i.plen_zero) begin
          cmd_o.op = sld_pkg::OP_LOAD_ZERO;
          state_d  = S_EOUT;
        end else begin
          state_d = S_ELOAD;
        end
      end
      S_ELOAD: begin
        cmd_o.op = sld_pkg::OP_LOAD_OUT;
        state_d  = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready_i) begin
          if (status_i.out_last) begin
            cmd_o.op = sld_pkg::OP_ACCEPT_DONE;
            state_d  = S_FIN;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_FIN: begin
        cmd_o.op = sld_pkg::OP_FINISH;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EOUT);

  `SLD_ASSERT_NR(a_one_side, clk_i, !(in_ready_o && out_valid_o))
  `SLD_ASSERT(a_take_append, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_APPEND))
  `SLD_ASSERT(a_run_cont, clk_i, rst_ni,
              (out_valid_o && out_ready_i && !status_i.out_last) |=> (state_q == S_EMIT))

endmodule

### rtl/core/sync_length_checksum_deframer.sv
// Sequence: an input byte is written to the store in the cycle after its request is taken;
// the search then passes states SRCH and SCMP for each held byte compared, HRD and HACC
// for each header byte, PRD and PACC for each byte under the checksum, EMIT, ELOAD and
// EOUT for each emitted payload byte plus output stall, and FIN drops consumed bytes
// before the next request can be taken. Flow: one byte at a time; the byte store has
// a single read port shared by search, check and emit.
// Reset: configuration returns to defaults and the store is empty; no clearing pass.
module sync_length_checksum_deframer #(
  parameter int unsigned SyncLen      = sld_pkg::SyncLenDefault,
  parameter int unsigned BufferDepth  = sld_pkg::BufferDepthDefault,
  parameter int unsigned PayloadLimit = sld_pkg::PayloadLimitDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sld_in_if.sink                          in_i,
  sld_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sld_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // The held bytes live in a circular store. The controller walks it through
  // a single read port: it hunts the sync pattern one candidate position at a
  // time, reads the header for its ID and length, sums header and payload, and
  // compares the trailing checksum when one is enabled; it then reads the payload
  // once more to hand it out as a run of requests. A rejected frame restarts the
  // hunt just past its sync bytes, so held bytes are rescanned without new input.
  sld_pkg::cfg_t       cfg;
  sld_pkg::dp_cmd_t    cmd;
  sld_pkg::dp_status_t status;

  sld_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath keeps the result fields in registers that hold still while
  // a request waits at the output.
  sld_dp #(
    .SyncLen      (SyncLen),
    .BufferDepth  (BufferDepth),
    .PayloadLimit (PayloadLimit)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .in_byte_i        (in_i.data_byte),
    .status_o         (status),
    .frame_id_o       (out_o.frame_id),
    .payload_byte_o   (out_o.payload_byte),
    .byte_valid_o     (out_o.byte_valid),
    .payload_length_o (out_o.payload_length),
    .last_o           (out_o.last)
  );

endmodule
